// File: src/b64sc_pkg.sv
package b64sc_pkg;

   // Default depth of the job queue between front and back end
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic       MODE_ENCODE    = 1'b0;
   localparam logic       MODE_DECODE    = 1'b1;
   localparam logic [7:0] PAD_CHAR       = 8'h3D;
   localparam logic [7:0] INVALID_SEXTET = 8'hFF;
   localparam logic [2:0] ENC_GROUP      = 3'd3;
   localparam logic [2:0] DEC_GROUP      = 3'd4;

   // One gathered group, handed from front to back end
   typedef struct packed {
      logic        mode;
      logic [31:0] store;
      logic [2:0]  count;
      logic        last;
   } job_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   // Map a sextet to its alphabet character
   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] ch;
      if (v < 6'd26) begin
         ch = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         ch = 8'h61 + {2'b00, v - 6'd26};
      end else if (v < 6'd62) begin
         ch = 8'h30 + {2'b00, v - 6'd52};
      end else if (v == 6'd62) begin
         ch = 8'h2B;
      end else begin
         ch = 8'h2F;
      end
      return ch;
   endfunction

   // Map a character to its sextet, URL-safe forms included
   function automatic logic [7:0] char_sextet(input logic [7:0] c);
      logic [7:0] s;
      if (c >= 8'h41 && c <= 8'h5A) begin
         s = c - 8'h41;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         s = c - 8'h61 + 8'd26;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         s = c - 8'h30 + 8'd52;
      end else if (c == 8'h2B || c == 8'h2D) begin
         s = 8'd62;
      end else if (c == 8'h2F || c == 8'h5F) begin
         s = 8'd63;
      end else begin
         s = INVALID_SEXTET;
      end
      return s;
   endfunction

endpackage

// File: src/b64sc_front.sv
module b64sc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic                csr_write_data,
   input  logic                req_valid,
   input  logic                req_data_byte_accept,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last_item,
   output logic                push_valid,
   output b64sc_pkg::job_type  push_job
);
   import b64sc_pkg::*;

   logic        mode_ff, mode_in;
   logic [31:0] store_ff, store_in;
   logic [1:0]  fill_ff, fill_in;

   logic        accept;
   logic [7:0]  item;
   logic [31:0] merged;
   logic [2:0]  count;
   logic        group_done;

   assign accept = req_valid && req_data_byte_accept;

   // Classify the item: raw byte when encoding, sextet when decoding
   always_comb begin
      item = (mode_ff == MODE_DECODE) ? char_sextet(req_data_byte) : req_data_byte;
      merged = store_ff;
      for (int k = 0; k < 4; k++) begin
         if (fill_ff == 2'(k)) begin
            merged[8*k +: 8] = item;
         end
      end
      count = {1'b0, fill_ff} + 3'd1;
      group_done = req_last_item ||
                   (count == ((mode_ff == MODE_DECODE) ? DEC_GROUP : ENC_GROUP));
   end

   assign push_valid     = accept && group_done;
   assign push_job.mode  = mode_ff;
   assign push_job.store = merged;
   assign push_job.count = count;
   assign push_job.last  = req_last_item;

   // Gather the group; a mode write starts over
   always_comb begin
      mode_in  = mode_ff;
      store_in = store_ff;
      fill_in  = fill_ff;
      if (csr_write_enable) begin
         mode_in  = csr_write_data;
         store_in = '0;
         fill_in  = '0;
      end else if (accept) begin
         if (group_done) begin
            store_in = '0;
            fill_in  = '0;
         end else begin
            store_in = merged;
            fill_in  = count[1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_ENCODE;
         store_ff <= '0;
         fill_ff  <= '0;
      end else begin
         mode_ff  <= mode_in;
         store_ff <= store_in;
         fill_ff  <= fill_in;
      end
   end

endmodule

// File: src/b64sc_queue.sv
module b64sc_queue #(
   parameter int DEPTH = b64sc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   input  b64sc_pkg::job_type           push_job,
   input  logic                         pop,
   output b64sc_pkg::job_type           head_job,
   output b64sc_pkg::queue_status_type  status
);
   import b64sc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == CNT_W'(DEPTH));
   assign head_job         = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap at the last slot
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("job queue holds more than its depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push_valid && status.full))
      else $error("job pushed into a full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && !status.not_empty))
      else $error("job popped from an empty queue");
   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      (push_valid && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");
`endif

endmodule

// File: src/b64sc_back.sv
module b64sc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  b64sc_pkg::job_type           head_job,
   input  b64sc_pkg::queue_status_type  status,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_out_byte,
   output logic                         rsp_out_last,
   output logic                         rsp_no_data
);
   import b64sc_pkg::*;

   // Current job, expanded into its result list
   logic       slot_busy_ff, slot_busy_in;
   logic [1:0] slot_idx_ff, slot_idx_in;
   logic [2:0] slot_cnt_ff;
   logic [7:0] slot_byte_ff [4];
   logic       slot_last_ff;
   logic       slot_nd_ff;

   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_last_ff;
   logic       rsp_nd_ff;

   logic       out_free, emit, final_entry, slot_free;

   logic [7:0] ld_byte [4];
   logic [2:0] ld_cnt;
   logic       ld_nd;
   logic [7:0] it [4];
   logic [7:0] v [4];
   logic [7:0] byt [3];
   logic [5:0] s [4];
   logic [2:0] pos;

   // Expand the head job into up to four results
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         it[k] = head_job.store[8*k +: 8];
         ld_byte[k] = '0;
      end
      ld_cnt = '0;
      ld_nd  = 1'b0;
      pos    = '0;
      s[0] = it[0][7:2];
      s[1] = {it[0][1:0], it[1][7:4]};
      s[2] = {it[1][3:0], it[2][7:6]};
      s[3] = it[2][5:0];
      for (int k = 0; k < 4; k++) begin
         v[k] = (3'(k) < head_job.count) ? it[k] : INVALID_SEXTET;
      end
      byt[0] = {v[0][5:0], v[1][5:4]};
      byt[1] = {v[1][3:0], v[2][5:2]};
      byt[2] = {v[2][1:0], v[3][5:0]};
      if (head_job.mode == MODE_ENCODE) begin
         for (int k = 0; k < 4; k++) begin
            ld_byte[k] = (3'(k) <= head_job.count) ? sextet_char(s[k]) : PAD_CHAR;
         end
         ld_cnt = 3'd4;
      end else begin
         // Drop each byte whose trailing sextet is invalid
         for (int k = 0; k < 3; k++) begin
            if (v[k+1] != INVALID_SEXTET) begin
               ld_byte[pos[1:0]] = byt[k];
               pos = pos + 3'd1;
            end
         end
         ld_cnt = pos;
         if (head_job.last && pos == 3'd0) begin
            ld_nd  = 1'b1;
            ld_cnt = 3'd1;
         end
      end
   end

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign emit        = slot_busy_ff && out_free;
   assign final_entry = ({1'b0, slot_idx_ff} + 3'd1) == slot_cnt_ff;
   assign slot_free   = !slot_busy_ff || (emit && final_entry);
   assign pop         = slot_free && status.not_empty;

   // Advance through the result list, load the next job behind the last one
   always_comb begin
      slot_busy_in = slot_busy_ff;
      slot_idx_in  = slot_idx_ff;
      if (pop) begin
         slot_busy_in = (ld_cnt != 3'd0);
         slot_idx_in  = '0;
      end else if (emit) begin
         if (final_entry) begin
            slot_busy_in = 1'b0;
         end
         slot_idx_in = slot_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_busy_ff <= 1'b0;
         slot_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_busy_ff <= slot_busy_in;
         slot_idx_ff  <= slot_idx_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold job payload and output payload
   always_ff @(posedge clock) begin
      if (pop) begin
         for (int k = 0; k < 4; k++) begin
            slot_byte_ff[k] <= ld_byte[k];
         end
         slot_cnt_ff  <= ld_cnt;
         slot_last_ff <= head_job.last;
         slot_nd_ff   <= ld_nd;
      end
      if (emit) begin
         rsp_byte_ff <= slot_byte_ff[slot_idx_ff];
         rsp_last_ff <= slot_last_ff && final_entry;
         rsp_nd_ff   <= slot_nd_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;
   assign rsp_no_data  = rsp_nd_ff;

`ifndef NO_ASSERTIONS
   a_nd_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_data) |-> rsp_out_last)
      else $error("end-only transaction without end mark");
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      slot_busy_ff |-> ({1'b0, slot_idx_ff} < slot_cnt_ff))
      else $error("result index beyond result count");
`endif

endmodule

// File: src/base64_stream_codec.sv
// Channel   Ports                                   Direction  Transaction
// req       req_valid req_stall req_data_byte        in         one byte or character
//           req_last_item
// rsp       rsp_valid rsp_stall rsp_out_byte         out        one character or byte
//           rsp_out_last rsp_no_data
// csr       csr_write_enable csr_write_data          in         codec_mode write
//
// Requests are taken one per cycle while the job queue has room; results leave
// one per cycle from the back end's output register while rsp_stall is low.
// The first result of a group passes through the job queue, the back end's slot
// and its output register after the edge that accepts its closing request.
// Reset (synchronous) selects encode mode and empties group, queue and output.
// A stalled response holds the back end; requests stall once the queue is full.
module base64_stream_codec #(
   parameter int QUEUE_DEPTH = b64sc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_item,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   output logic       rsp_no_data,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);
   import b64sc_pkg::*;

   logic             push_valid;
   job_type          push_job;
   job_type          head_job;
   queue_status_type status;
   logic             pop;

   assign req_stall = status.full;

   b64sc_front u_front (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_data_byte_accept (!status.full),
      .req_data_byte        (req_data_byte),
      .req_last_item        (req_last_item),
      .push_valid           (push_valid),
      .push_job             (push_job)
   );

   b64sc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .head_job   (head_job),
      .status     (status)
   );

   b64sc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_job     (head_job),
      .status       (status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .rsp_no_data  (rsp_no_data)
   );

endmodule

// File: tb/sv/base64_stream_codec_test.sv
`timescale 1ns / 100ps

module base64_stream_codec_test;
   import b64sc_pkg::*;

   // One expected character or byte on the response channel
   typedef struct packed {
      logic [7:0] value;
      logic       ends_msg;
      logic       mark_only;
   } codec_out_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_data_byte;
   logic       req_last_item;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;
   logic       rsp_no_data;
   logic       csr_write_enable;
   logic       csr_write_data;

   // Shadow copy of the codec state
   logic        mode_reg;
   logic [31:0] gather_word;
   int          gather_count;

   codec_out_type codec_output_queue[$];
   int            mismatch_count;
   bit            sender_gaps_on;
   bit            receiver_gaps_on;
   int            rsp_hold_cycles;

   string b64_alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   base64_stream_codec i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_item    (req_last_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_last     (rsp_out_last),
      .rsp_no_data      (rsp_no_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Stop a hung run
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
      return b64_alphabet[s];
   endfunction

   // Standard alphabet plus the URL-safe forms; anything else is invalid
   function automatic logic [7:0] char_to_sextet(input logic [7:0] c);
      logic [7:0] s;
      s = INVALID_SEXTET;
      for (int i = 0; i < 64; i++) begin
         if (b64_alphabet[i] == c) s = i[7:0];
      end
      if (c == "-") s = 8'd62;
      if (c == "_") s = 8'd63;
      return s;
   endfunction

   // Gather up to three bytes and emit four characters, padded on a short tail
   task automatic compute_encoded_chars(input logic [7:0] b, input logic last);
      logic [7:0] b0, b1, b2;
      logic [5:0] s[4];
      codec_out_type r;
      int n;
      n = gather_count;
      gather_word[8*n +: 8] = b;
      n++;
      if (n < 3 && !last) begin
         gather_count = n;
         return;
      end
      b0 = gather_word[7:0];
      b1 = (n > 1) ? gather_word[15:8] : 8'h00;
      b2 = (n > 2) ? gather_word[23:16] : 8'h00;
      s[0] = b0[7:2];
      s[1] = {b0[1:0], b1[7:4]};
      s[2] = {b1[3:0], b2[7:6]};
      s[3] = b2[5:0];
      for (int k = 0; k < 4; k++) begin
         r.value     = (k <= n) ? sextet_to_char(s[k]) : PAD_CHAR;
         r.ends_msg  = (k == 3) ? last : 1'b0;
         r.mark_only = 1'b0;
         codec_output_queue = {codec_output_queue, r};
      end
      gather_word  = '0;
      gather_count = 0;
   endtask

   // Gather up to four characters and emit the bytes whose trailing sextet is valid
   task automatic compute_decoded_bytes(input logic [7:0] c, input logic last);
      logic [7:0] v[4];
      logic [7:0] byt[3];
      codec_out_type outs[$];
      codec_out_type r;
      int n;
      n = gather_count;
      gather_word[8*n +: 8] = char_to_sextet(c);
      n++;
      if (n < 4 && !last) begin
         gather_count = n;
         return;
      end
      for (int k = 0; k < 4; k++) begin
         v[k] = (k < n) ? gather_word[8*k +: 8] : INVALID_SEXTET;
      end
      byt[0] = {v[0][5:0], v[1][5:4]};
      byt[1] = {v[1][3:0], v[2][5:2]};
      byt[2] = {v[2][1:0], v[3][5:0]};
      for (int k = 0; k < 3; k++) begin
         if (v[k+1] != INVALID_SEXTET) begin
            r.value     = byt[k];
            r.ends_msg  = 1'b0;
            r.mark_only = 1'b0;
            outs = {outs, r};
         end
      end
      // An empty tail still carries the end mark
      if (last) begin
         if (outs.size() == 0) begin
            r.value     = 8'h00;
            r.ends_msg  = 1'b1;
            r.mark_only = 1'b1;
            outs = {outs, r};
         end else begin
            outs[outs.size()-1].ends_msg = 1'b1;
         end
      end
      codec_output_queue = {codec_output_queue, outs};
      gather_word  = '0;
      gather_count = 0;
   endtask

   task automatic compute_codec_output(input logic [7:0] b, input logic last);
      if (mode_reg == MODE_DECODE) begin
         compute_decoded_bytes(b, last);
      end else begin
         compute_encoded_chars(b, last);
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("%0t: MISMATCH %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Offer one transaction after a random gap and predict on acceptance
   task automatic send_item(input logic [7:0] b, input logic last);
      int gap;
      gap = sender_gaps_on ? $urandom_range(0, 19) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_item <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      compute_codec_output(b, last);
   endtask

   // Drop valid and wait until every predicted result has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (codec_output_queue.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_codec_mode(input logic m);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= m;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      mode_reg     = m;
      gather_word  = '0;
      gather_count = 0;
   endtask

   // Mostly alphabet characters, some URL-safe, padding and raw noise
   function automatic logic [7:0] pick_text_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return b64_alphabet[$urandom_range(0, 63)];
      if (r < 85) return ($urandom_range(0, 1) != 0) ? 8'h2D : 8'h5F;
      if (r < 90) return PAD_CHAR;
      return 8'($urandom_range(0, 255));
   endfunction

   // Full group, then one- and two-byte tails
   task automatic test_encode_directed();
      write_codec_mode(MODE_ENCODE);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'h7F, 1'b1);
      send_item(8'h01, 1'b0);
      send_item(8'hFE, 1'b1);
   endtask

   // A mode write discards a half-gathered group
   task automatic test_mode_write_clears();
      wait_drained();
      send_item(8'hA5, 1'b0);
      send_item(8'h5A, 1'b0);
      wait_drained();
      write_codec_mode(MODE_DECODE);
   endtask

   // URL-safe forms, invalid codes, padding-only and invalid-first tails
   task automatic test_decode_directed();
      send_item("-", 1'b0);
      send_item("_", 1'b0);
      send_item("+", 1'b0);
      send_item("/", 1'b0);
      send_item("z", 1'b0);
      send_item("9", 1'b0);
      send_item(8'h7B, 1'b0);
      send_item(8'hFF, 1'b1);
      send_item(PAD_CHAR, 1'b1);
      send_item(8'h00, 1'b0);
      send_item("a", 1'b1);
      send_item("T", 1'b0);
      send_item("Q", 1'b1);
   endtask

   // Hold the receiver off while the sender keeps offering, then pause
   task automatic test_backpressure();
      wait_drained();
      write_codec_mode(MODE_ENCODE);
      sender_gaps_on  = 1'b0;
      rsp_hold_cycles = 80;
      for (int i = 0; i < 30; i++) begin
         send_item(8'($urandom_range(0, 255)), (i % 7) == 6);
      end
      wait_drained();
      sender_gaps_on = 1'b1;
   endtask

   // Random messages in phases with alternating, sometimes random, mode and idling
   task automatic test_random_traffic();
      logic       m;
      logic [7:0] b;
      logic       last;
      int         len;
      for (int phase = 0; phase < 12; phase++) begin
         wait_drained();
         m = ((phase % 3) == 2) ? logic'($urandom_range(0, 1)) : logic'(phase % 2);
         write_codec_mode(m);
         sender_gaps_on   = (phase % 4) != 3;
         receiver_gaps_on = (phase % 4) != 2;
         for (int msg = 0; msg < 4; msg++) begin
            if (m == MODE_DECODE && $urandom_range(0, 4) != 0) begin
               len = 4 * $urandom_range(1, 3);
            end else begin
               len = $urandom_range(1, 12);
            end
            for (int i = 0; i < len; i++) begin
               b    = (m == MODE_DECODE) ? pick_text_char() : 8'($urandom_range(0, 255));
               last = (i == len - 1) && ($urandom_range(0, 19) != 0);
               send_item(b, last);
            end
         end
      end
      sender_gaps_on   = 1'b1;
      receiver_gaps_on = 1'b1;
   endtask

   // Receiver: stall before each transaction, for a random gap or a requested hold
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         if (rsp_hold_cycles > 0) begin
            n = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            n = receiver_gaps_on ? $urandom_range(0, 19) : 0;
         end
         repeat (n) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
      end
   end

   // Compare each response transaction with the oldest prediction
   always @(posedge clock) begin : rsp_check
      codec_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (codec_output_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte %h", rsp_out_byte));
         end else begin
            want = codec_output_queue.pop_front();
            if (rsp_out_byte !== want.value) begin
               report_mismatch($sformatf("out_byte %h, want %h", rsp_out_byte, want.value));
            end
            if (rsp_out_last !== want.ends_msg) begin
               report_mismatch($sformatf("out_last %b, want %b", rsp_out_last, want.ends_msg));
            end
            if (rsp_no_data !== want.mark_only) begin
               report_mismatch($sformatf("no_data %b, want %b", rsp_no_data, want.mark_only));
            end
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data_byte    = 8'h00;
      req_last_item    = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      mode_reg         = MODE_ENCODE;
      gather_word      = '0;
      gather_count     = 0;
      mismatch_count   = 0;
      sender_gaps_on   = 1'b1;
      receiver_gaps_on = 1'b1;
      rsp_hold_cycles  = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_encode_directed();
      test_mode_write_clears();
      test_decode_directed();
      test_backpressure();
      test_random_traffic();

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
